// File: rtl/ptb_pkg.sv
package ptb_pkg;

   localparam int NUM_TIMERS_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int MAX_RESULTS     = 8;
   localparam int EV_W            = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_START    = 2'd1,
      REQ_KILL     = 2'd2,
      REQ_KILL_ALL = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KILL,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

endpackage

// File: rtl/periodic_timer_bank_top.sv
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tuser: request kind; tdata: id, period, link
// rsp       out  rsp_tvalid/tready    tdata: expired id; tlast: last event of a tick
//
// Start writes the entry straight from the request. Kill reads the reload, then writes it
// into the count. Kill-all and a tick with link up sweep the whole memory; the sweep waits
// while an event must go to a full result register, and a tick with events flushes the last.
// The single timer memory is swept one entry per cycle, unless such a push stall holds it.
// Reset is synchronous, active high; per-entry valid bits make every timer read
// as zero after reset, so no clearing pass is needed.
// A stalled rsp side only holds the sweep when a new event must be pushed.
module periodic_timer_bank_top #(
   parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [23:0] req_tdata,   // [2:0] timer_id, [18:3] period, [19] link_up, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] expired_id, zero pad
   output logic        rsp_tlast    // last_of_run
);
   import ptb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int CW    = COUNT_WIDTH;

   // request fields
   req_kind_type      req_kind;
   logic [2:0]        req_id;
   logic [CW-1:0]     req_period;
   logic              req_link;
   logic              req_id_ok;
   logic [IDX_W-1:0]  req_idx;
   logic              req_fire;

   assign req_kind   = req_kind_type'(req_tuser);
   assign req_id     = req_tdata[2:0];
   assign req_period = CW'(req_tdata[18:3]);
   assign req_link   = req_tdata[19];
   assign req_id_ok  = (32'(req_id) < 32'(NUM_TIMERS));
   assign req_idx    = IDX_W'(req_id);
   assign req_fire   = req_tvalid & req_tready;

   // timer memory: {reload, count} per entry
   logic [2*CW-1:0] mem [NUM_TIMERS];
   logic [2*CW-1:0] rdata_ff;

   logic            mem_we;
   logic [IDX_W-1:0] wr_addr;
   logic [2*CW-1:0] wr_data;
   logic            rd_en;
   logic [IDX_W-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // control state
   state_type         state_ff, state_in;
   logic [NUM_TIMERS-1:0] en_ff, en_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic              tick_op_ff, tick_op_in;
   logic [EV_W-1:0]   ev_cnt_ff, ev_cnt_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              out_vld_ff, out_vld_in;
   logic [2:0]        out_id_ff, out_id_in;
   logic              out_last_ff, out_last_in;

   // entry under work
   logic [CW-1:0] cur_rel, cur_cnt, base_cnt, new_cnt;
   logic          cur_en, ev_hit, need_push, out_free, stall, issue, sweep_done;

   assign cur_rel  = valid_ff[s1_idx_ff] ? rdata_ff[2*CW-1:CW] : '0;
   assign cur_cnt  = valid_ff[s1_idx_ff] ? rdata_ff[CW-1:0]    : '0;
   assign cur_en   = en_ff[s1_idx_ff];
   assign base_cnt = (cur_cnt == '0) ? cur_rel : cur_cnt;
   assign new_cnt  = (cur_en && (base_cnt != '0)) ? base_cnt - CW'(1) : base_cnt;

   // an enabled timer at zero fires, up to the per-tick event limit
   assign ev_hit    = (state_ff == ST_SWEEP) & s1_vld_ff & tick_op_ff & cur_en &
                      (cur_cnt == '0) & (ev_cnt_ff < EV_W'(MAX_RESULTS));
   assign out_free  = ~out_vld_ff | rsp_tready;
   assign need_push = ev_hit & pend_vld_ff;
   assign stall     = need_push & ~out_free;
   assign issue     = (state_ff == ST_SWEEP) & (rd_cnt_ff < CNT_W'(NUM_TIMERS)) & ~stall;
   assign sweep_done = (rd_cnt_ff == CNT_W'(NUM_TIMERS)) & ~s1_vld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  REQ_KILL:     state_in = req_id_ok ? ST_KILL : ST_IDLE;
                  REQ_KILL_ALL: state_in = ST_SWEEP;
                  REQ_TICK:     state_in = req_link ? ST_SWEEP : ST_IDLE;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_KILL:  state_in = ST_IDLE;
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = pend_vld_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      mem_we      = 1'b0;
      wr_addr     = s1_idx_ff;
      wr_data     = {cur_rel, new_cnt};
      rd_en       = 1'b0;
      rd_addr     = rd_cnt_ff[IDX_W-1:0];
      en_in       = en_ff;
      valid_in    = valid_ff;
      rd_cnt_in   = rd_cnt_ff;
      s1_vld_in   = s1_vld_ff;
      s1_idx_in   = s1_idx_ff;
      tick_op_in  = tick_op_ff;
      ev_cnt_in   = ev_cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      out_vld_in  = out_vld_ff & ~rsp_tready;
      out_id_in   = out_id_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_cnt_in  = '0;
            s1_vld_in  = 1'b0;
            ev_cnt_in  = '0;
            tick_op_in = (req_kind == REQ_TICK);
            if (req_fire && req_id_ok && (req_kind == REQ_START)) begin
               mem_we            = 1'b1;
               wr_addr           = req_idx;
               wr_data           = {req_period, req_period};
               en_in[req_idx]    = 1'b1;
               valid_in[req_idx] = 1'b1;
            end
            if (req_fire && req_id_ok && (req_kind == REQ_KILL)) begin
               rd_en     = 1'b1;
               rd_addr   = req_idx;
               s1_idx_in = req_idx;
            end
         end
         ST_KILL: begin
            // copy reload into count, drop enable
            mem_we              = 1'b1;
            wr_data             = {cur_rel, cur_rel};
            en_in[s1_idx_ff]    = 1'b0;
            valid_in[s1_idx_ff] = 1'b1;
         end
         ST_SWEEP: begin
            if (s1_vld_ff && !stall) begin
               mem_we              = 1'b1;
               valid_in[s1_idx_ff] = 1'b1;
               if (!tick_op_ff) begin
                  wr_data          = {cur_rel, cur_rel};
                  en_in[s1_idx_ff] = 1'b0;
               end
               if (ev_hit) begin
                  ev_cnt_in   = ev_cnt_ff + EV_W'(1);
                  pend_vld_in = 1'b1;
                  pend_idx_in = s1_idx_ff;
               end
               if (need_push) begin
                  out_vld_in  = 1'b1;
                  out_id_in   = 3'(pend_idx_ff);
                  out_last_in = 1'b0;
               end
            end
            if (!stall) begin
               rd_en     = issue;
               s1_vld_in = issue;
               s1_idx_in = rd_cnt_ff[IDX_W-1:0];
               if (issue) begin
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_id_in   = 3'(pend_idx_ff);
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: begin
            s1_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         en_ff       <= '0;
         valid_ff    <= '0;
         rd_cnt_ff   <= '0;
         s1_vld_ff   <= 1'b0;
         ev_cnt_ff   <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         tick_op_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         en_ff       <= en_in;
         valid_ff    <= valid_in;
         rd_cnt_ff   <= rd_cnt_in;
         s1_vld_ff   <= s1_vld_in;
         ev_cnt_ff   <= ev_cnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         tick_op_ff  <= tick_op_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= s1_idx_in;
      pend_idx_ff <= pend_idx_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_id_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   // a new request is only taken with the sweep and the held event drained
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!s1_vld_ff && !pend_vld_ff))
      else $error("request taken with sweep work outstanding");

   // never more events per tick than the limit
   a_ev_limit: assert property (@(posedge clock) disable iff (reset)
      ev_cnt_ff <= EV_W'(MAX_RESULTS))
      else $error("event count above limit");

   // write-back and the next read never hit the same entry
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same timer entry");
`endif

endmodule
